FILE: rtl/orbw_pkg.sv
package orbw_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = 7;
  localparam int LEN_W      = 7;
  localparam int RES_W      = 32;
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = 2;
  localparam int OQ_CNT_W   = 3;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WINDOW = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WINDOW
  } seq_state_t;

  typedef struct packed {
    logic [RES_W-1:0] rdata;
    logic             valid_res;
    logic             last;
    logic             dropped_oldest;
    logic [CNT_W-1:0] fill_count;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      addr;
    logic [DATA_WIDTH-1:0] wdata;
  } ram_req_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(CAPACITY - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

endpackage

FILE: rtl/overwriting_ring_buffer_window_core.sv
// Overwriting ring buffer of 64 words with a window snapshot. Each request on
// the slave side carries a command in s_tuser: write (store a word; when the
// buffer is full the oldest word is dropped and the response says so), read
// (pop the oldest word, or an empty response), window (stream the oldest
// min(window_len, fill) words without removing them, tlast on the final one;
// a zero-length window gives one empty response with tlast). Every request
// yields at least one response, and every response carries the fill count
// after the request. A window of n words holds the slave side until its last word
// is issued, one word per cycle while the output queue has room, paced by the
// single port of the word memory. Each response passes through the registered
// memory read stage and then the output queue. A four-entry output queue
// decouples the master side; when it backs up, s_tready and the window stream
// hold until there is room. No clearing pass is needed after reset: a word is
// only read after it has been written.
module overwriting_ring_buffer_window_core import orbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] wdata, [38:32] window_len, [39] zero
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] rdata, [32] dropped_oldest, [39:33] fill_count
  output logic [0:0]  m_tuser,   // [0] valid_res
  output logic        m_tlast    // last
);

  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] ram_q;
  logic                  push;
  result_t               push_res;
  result_t               out_res;
  logic [OQ_CNT_W-1:0]   oq_count;

  // Command sequencer: pointers, fill count and window walk.
  orbw_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cmd        (s_tuser),
    .wdata      (s_tdata[31:0]),
    .window_len (s_tdata[38:32]),
    .oq_count   (oq_count),
    .ram_req    (ram_req),
    .ram_q      (ram_q),
    .push       (push),
    .push_res   (push_res)
  );

  // Word store; contents undefined until written.
  orbw_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (DATA_WIDTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_q)
  );

  // Output queue; hold responses while the master side stalls.
  orbw_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .count     (oq_count)
  );

  assign m_tdata = {out_res.fill_count, out_res.dropped_oldest, out_res.rdata};
  assign m_tuser = out_res.valid_res;
  assign m_tlast = out_res.last;

endmodule

FILE: rtl/orbw_ram.sv
module orbw_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port; read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/orbw_seq.sv
module orbw_seq import orbw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [RES_W-1:0]      wdata,
  input  logic [LEN_W-1:0]      window_len,
  input  logic [OQ_CNT_W-1:0]   oq_count,
  output ram_req_t              ram_req,
  input  logic [DATA_WIDTH-1:0] ram_q,
  output logic                  push,
  output result_t               push_res
);

  seq_state_t       state, state_next;
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [PTR_W-1:0] win_ptr, win_ptr_next;
  logic [CNT_W-1:0] win_left, win_left_next;

  logic             stage_valid;
  logic             stage_use_ram;
  result_t          stage_res;

  logic             issue;
  logic             issue_use_ram;
  result_t          issue_res;
  logic             credit;
  logic [CNT_W-1:0] win_n;

  // Room for one more result counting the one already in the read stage.
  assign credit = (oq_count + OQ_CNT_W'(stage_valid)) < OQ_CNT_W'(OQ_DEPTH);
  assign win_n  = (window_len < fill) ? window_len : fill;

  always_comb begin
    state_next     = state;
    read_ptr_next  = read_ptr;
    write_ptr_next = write_ptr;
    fill_next      = fill;
    win_ptr_next   = win_ptr;
    win_left_next  = win_left;
    in_ready       = (state == ST_IDLE) && credit;
    issue          = 1'b0;
    issue_use_ram  = 1'b0;
    issue_res      = '0;
    ram_req.we     = 1'b0;
    ram_req.addr   = read_ptr;
    ram_req.wdata  = wdata[DATA_WIDTH-1:0];

    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          issue                = 1'b1;
          issue_res.last       = 1'b1;
          issue_res.fill_count = fill;
          case (cmd_t'(cmd))
            CMD_WRITE: begin
              ram_req.we     = 1'b1;
              ram_req.addr   = write_ptr;
              write_ptr_next = ptr_inc(write_ptr);
              if (fill == CNT_W'(CAPACITY)) begin
                read_ptr_next            = ptr_inc(read_ptr);
                issue_res.dropped_oldest = 1'b1;
              end else begin
                fill_next            = fill + CNT_W'(1);
                issue_res.fill_count = fill + CNT_W'(1);
              end
            end
            CMD_READ: begin
              if (fill != '0) begin
                issue_use_ram        = 1'b1;
                issue_res.valid_res  = 1'b1;
                read_ptr_next        = ptr_inc(read_ptr);
                fill_next            = fill - CNT_W'(1);
                issue_res.fill_count = fill - CNT_W'(1);
              end
            end
            CMD_WINDOW: begin
              if (win_n != '0) begin
                issue_use_ram       = 1'b1;
                issue_res.valid_res = 1'b1;
                issue_res.last      = (win_n == CNT_W'(1));
                win_ptr_next        = ptr_inc(read_ptr);
                win_left_next       = win_n - CNT_W'(1);
                if (win_n != CNT_W'(1)) begin
                  state_next = ST_WINDOW;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WINDOW: begin
        if (credit) begin
          issue                = 1'b1;
          issue_use_ram        = 1'b1;
          ram_req.addr         = win_ptr;
          issue_res.valid_res  = 1'b1;
          issue_res.last       = (win_left == CNT_W'(1));
          issue_res.fill_count = fill;
          win_ptr_next         = ptr_inc(win_ptr);
          win_left_next        = win_left - CNT_W'(1);
          if (win_left == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      read_ptr    <= '0;
      write_ptr   <= '0;
      fill        <= '0;
      win_ptr     <= '0;
      win_left    <= '0;
      stage_valid <= 1'b0;
    end else begin
      state       <= state_next;
      read_ptr    <= read_ptr_next;
      write_ptr   <= write_ptr_next;
      fill        <= fill_next;
      win_ptr     <= win_ptr_next;
      win_left    <= win_left_next;
      stage_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    stage_use_ram <= issue_use_ram;
    stage_res     <= issue_res;
  end

  // Merge memory read data into the staged result.
  always_comb begin
    push_res = stage_res;
    if (stage_use_ram) begin
      push_res.rdata = RES_W'(ram_q);
    end
  end
  assign push = stage_valid;

endmodule

FILE: rtl/orbw_outq.sv
module orbw_outq import orbw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  result_t             push_res,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             out_res,
  output logic [OQ_CNT_W-1:0] count
);

  result_t              slots [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_ptr;
  logic [OQ_PTR_W-1:0]  rd_ptr;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_res   = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_res;
    end
  end

endmodule
